### design/vcd_pkg.sv
// Shared types and constants for the vec3 change detector.
package vcd_pkg;

	localparam int THR_BITS   = 16;
	localparam int TICK_BITS  = 32;
	localparam int DELTA_BITS = 17;
	localparam int HIT_BITS   = 16;
	localparam int LANES      = 3;
	localparam int OUT_BITS   = 1 + LANES * DELTA_BITS + LANES * HIT_BITS;
	localparam int OUT_TDATA_BITS = ((OUT_BITS + 7) / 8) * 8;
	localparam int CFG_DATA_BITS  = 32;
	localparam int CFG_IDX_BITS   = 2;

	// register indexes
	localparam logic [CFG_IDX_BITS-1:0] REG_THRESHOLD = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_MODE      = 2'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_HOLDOFF   = 2'd2;
	localparam logic [CFG_IDX_BITS-1:0] REG_PREVENT   = 2'd3;

	// detect mode codes
	localparam logic [1:0] MODE_ANY = 2'd0;
	localparam logic [1:0] MODE_INC = 2'd1;
	localparam logic [1:0] MODE_DEC = 2'd2;

	typedef struct packed {
		logic [THR_BITS-1:0]  thr;
		logic [1:0]           mode;
		logic [TICK_BITS-1:0] min_ticks;
		logic                 prevent;
	} cfg_t;

	typedef struct packed {
		logic                        over;
		logic signed [DELTA_BITS-1:0] delta;
		logic [HIT_BITS-1:0]         abs_delta;
	} lane_res_t;

endpackage

### design/vcd_lane.sv
// One component lane: delta against the previous sample, threshold test, saturation.
module vcd_lane #(
	parameter int SAMPLE_BITS = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   fire,
	input  logic [SAMPLE_BITS-1:0] sample,
	input  vcd_pkg::cfg_t          cfg,
	output vcd_pkg::lane_res_t     res
);

	localparam int DW = SAMPLE_BITS + 1;
	localparam int CW = ((DW > vcd_pkg::DELTA_BITS) ? DW : vcd_pkg::DELTA_BITS) + 1;
	localparam logic signed [CW-1:0] LIM = CW'(65535);

	logic [SAMPLE_BITS-1:0] prev_q;
	logic signed [DW-1:0]   d_raw;
	logic signed [CW-1:0]   d;
	logic signed [CW-1:0]   thr;
	logic signed [CW-1:0]   mag;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q <= '0;
		end else if (fire) begin
			prev_q <= sample;
		end
	end

	always_comb begin
		d_raw = $signed({sample[SAMPLE_BITS-1], sample}) - $signed({prev_q[SAMPLE_BITS-1], prev_q});
		d     = {{(CW-DW){d_raw[DW-1]}}, d_raw};
		thr   = $signed({{(CW-vcd_pkg::THR_BITS){1'b0}}, cfg.thr});
		mag   = (d < 0) ? -d : d;

		case (cfg.mode)
			vcd_pkg::MODE_ANY: res.over = (d > thr) || (d < -thr);
			vcd_pkg::MODE_INC: res.over = (d > thr);
			default:           res.over = (d < -thr);  // decrease, unused code too
		endcase

		if (d > LIM) begin
			res.delta = vcd_pkg::DELTA_BITS'(65535);
		end else if (d < -LIM) begin
			res.delta = -vcd_pkg::DELTA_BITS'(65535);
		end else begin
			res.delta = d[vcd_pkg::DELTA_BITS-1:0];
		end

		res.abs_delta = (mag > LIM) ? {vcd_pkg::HIT_BITS{1'b1}} : mag[vcd_pkg::HIT_BITS-1:0];
	end

endmodule

### design/vcd_merge.sv
// Merge stage: combines lane flags, edge and holdoff qualification, hit latch.
module vcd_merge (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            fire,
	input  logic [vcd_pkg::TICK_BITS-1:0]   timestamp,
	input  vcd_pkg::cfg_t                   cfg,
	input  vcd_pkg::lane_res_t              lane_res [vcd_pkg::LANES],
	output logic                            changed,
	output logic [vcd_pkg::HIT_BITS-1:0]    hit_delta [vcd_pkg::LANES]
);

	logic                          was_over_q;
	logic [vcd_pkg::TICK_BITS-1:0] last_hit_q;
	logic [vcd_pkg::HIT_BITS-1:0]  latched_q [vcd_pkg::LANES];
	logic                          over;
	logic                          cand;
	logic                          holdoff_ok;
	logic                          take;
	logic [vcd_pkg::TICK_BITS-1:0] elapsed;

	always_comb begin
		over = 1'b0;
		for (int i = 0; i < vcd_pkg::LANES; i++) begin
			over = over | lane_res[i].over;
		end
		cand       = over && (cfg.prevent || !was_over_q);
		elapsed    = timestamp - last_hit_q;  // wraps mod 2^32
		holdoff_ok = (elapsed >= cfg.min_ticks);
		take       = cand && holdoff_ok;
		// an over sample that is not a candidate still reports changed
		changed    = over && !(cand && !holdoff_ok);
		for (int i = 0; i < vcd_pkg::LANES; i++) begin
			hit_delta[i] = take ? lane_res[i].abs_delta : latched_q[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			was_over_q <= 1'b0;
			last_hit_q <= '0;
			for (int i = 0; i < vcd_pkg::LANES; i++) begin
				latched_q[i] <= '0;
			end
		end else if (fire) begin
			was_over_q <= over;
			if (take) begin
				last_hit_q <= timestamp;
			end
			for (int i = 0; i < vcd_pkg::LANES; i++) begin
				latched_q[i] <= hit_delta[i];
			end
		end
	end

endmodule

### design/vec3_change_detector_unit.sv
// Top level of the vec3 change detector: config registers, lanes, merge, output register.
//
// Input stream s_*: one beat per sample. s_tdata from bit 0 up: sample_x, sample_y,
// sample_z (SAMPLE_BITS each, signed Q8.8), timestamp (32 bit ticks), zero padded.
// Output stream m_*: one beat per input beat. m_tdata from bit 0 up: changed,
// delta_x, delta_y, delta_z (17 bit signed), hit_delta_x/y/z (16 bit), zero padded.
// Config: cfg_we writes cfg_data into register cfg_index (0 threshold, 1 mode,
// 2 holdoff ticks, 3 prevent_continued) at the clock edge; write only while idle.
//
// Results are registered: a sample accepted at one edge shows on m_* right after it.
// Throughput is one sample per cycle while the receiver takes each beat; the three component
// lanes and the merge stage are combinational against the stored previous sample and hit state.
// The single output register lets s_tready stay high while m_tready is high or the
// register is empty; when the receiver stalls with a beat held, s_tready drops and
// the held beat stays unchanged.
// Reset (arst_n low) clears the registers, previous sample, hit state and the
// output valid flag.
module vec3_change_detector_unit #(
	parameter int SAMPLE_BITS = 16
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   s_tvalid,
	output logic                                   s_tready,
	// sample_x, sample_y, sample_z, timestamp
	input  logic [((3*SAMPLE_BITS+32+7)/8)*8-1:0]  s_tdata,
	output logic                                   m_tvalid,
	input  logic                                   m_tready,
	// changed, delta_x, delta_y, delta_z, hit_delta_x, hit_delta_y, hit_delta_z
	output logic [vcd_pkg::OUT_TDATA_BITS-1:0]     m_tdata,
	input  logic                                   cfg_we,
	input  logic [vcd_pkg::CFG_IDX_BITS-1:0]       cfg_index,
	input  logic [vcd_pkg::CFG_DATA_BITS-1:0]      cfg_data
);

	localparam int TS_LO = vcd_pkg::LANES * SAMPLE_BITS;

	vcd_pkg::cfg_t                 cfg_q;
	vcd_pkg::lane_res_t            lane_res [vcd_pkg::LANES];
	logic [vcd_pkg::HIT_BITS-1:0]  hit_delta [vcd_pkg::LANES];
	logic                          changed;
	logic                          fire;
	logic                          out_valid_q;
	logic [vcd_pkg::OUT_BITS-1:0]  out_data_s1;
	logic [vcd_pkg::OUT_BITS-1:0]  out_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				vcd_pkg::REG_THRESHOLD: cfg_q.thr       <= cfg_data[vcd_pkg::THR_BITS-1:0];
				vcd_pkg::REG_MODE:      cfg_q.mode      <= cfg_data[1:0];
				vcd_pkg::REG_HOLDOFF:   cfg_q.min_ticks <= cfg_data[vcd_pkg::TICK_BITS-1:0];
				vcd_pkg::REG_PREVENT:   cfg_q.prevent   <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign s_tready = !out_valid_q || m_tready;
	assign fire     = s_tvalid && s_tready;

	for (genvar i = 0; i < vcd_pkg::LANES; i++) begin : g_lane
		vcd_lane #(.SAMPLE_BITS(SAMPLE_BITS)) u_lane (
			.clk    (clk),
			.arst_n (arst_n),
			.fire   (fire),
			.sample (s_tdata[i*SAMPLE_BITS +: SAMPLE_BITS]),
			.cfg    (cfg_q),
			.res    (lane_res[i])
		);
	end

	vcd_merge u_merge (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (fire),
		.timestamp (s_tdata[TS_LO +: vcd_pkg::TICK_BITS]),
		.cfg       (cfg_q),
		.lane_res  (lane_res),
		.changed   (changed),
		.hit_delta (hit_delta)
	);

	always_comb begin
		out_next = {hit_delta[2], hit_delta[1], hit_delta[0],
			lane_res[2].delta, lane_res[1].delta, lane_res[0].delta, changed};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			out_data_s1 <= out_next;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(vcd_pkg::OUT_TDATA_BITS-vcd_pkg::OUT_BITS){1'b0}}, out_data_s1};

endmodule

### design/vcd_checker.sv
// Port-level checker for the vec3 change detector, bound to the top level.
module vcd_checker #(
	parameter int SAMPLE_BITS = 16
) (
	input logic                                   clk,
	input logic                                   arst_n,
	input logic                                   s_tvalid,
	input logic                                   s_tready,
	input logic [((3*SAMPLE_BITS+32+7)/8)*8-1:0]  s_tdata,
	input logic                                   m_tvalid,
	input logic                                   m_tready,
	input logic [vcd_pkg::OUT_TDATA_BITS-1:0]     m_tdata,
	input logic                                   cfg_we,
	input logic [vcd_pkg::CFG_IDX_BITS-1:0]       cfg_index,
	input logic [vcd_pkg::CFG_DATA_BITS-1:0]      cfg_data
);

	// held beat stays put
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("output beat changed while stalled");

	// every accepted sample yields a result beat next cycle
	a_result: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> m_tvalid)
		else $error("accepted sample produced no result");

	// input side is open exactly when the output register can take a beat
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready == (!m_tvalid || m_tready))
		else $error("s_tready does not track output register space");

	// no beat appears without an accepted sample
	a_no_extra: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_tvalid && s_tready) && !(m_tvalid && !m_tready) |=> !m_tvalid)
		else $error("result beat without accepted sample");

endmodule

bind vec3_change_detector_unit vcd_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_vcd_checker (.*);

### tb/vec3_change_detector_unit_test.sv
// Self-checking testbench for vec3_change_detector_unit: directed and random sample streams.
`timescale 1ns / 100ps

module vec3_change_detector_unit_test;

	localparam int SAMPLE_W       = 16;
	localparam int IN_TDATA_BITS  = ((3 * SAMPLE_W + 32 + 7) / 8) * 8;
	localparam int DELTA_LIMIT    = 65535;
	localparam int MAG_LIMIT      = 65535;
	localparam int DRAIN_SLACK    = 4;
	localparam int LONG_HOLD_CYC  = 300;
	localparam int RANDOM_PHASES  = 10;
	localparam int PHASE_BEATS    = 196;
	localparam longint TIMEOUT_NS = 64'd3_000_000;
	// 0.5 in Q8.8
	localparam logic [15:0] HALF_Q88 = 16'h0080;

	typedef struct {
		logic signed [15:0] x;
		logic signed [15:0] y;
		logic signed [15:0] z;
		logic [31:0]        ts;
	} sample_t;

	typedef struct {
		logic               changed;
		logic signed [16:0] dx;
		logic signed [16:0] dy;
		logic signed [16:0] dz;
		logic [15:0]        hx;
		logic [15:0]        hy;
		logic [15:0]        hz;
	} detection_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	// sample_x, sample_y, sample_z, timestamp
	logic [IN_TDATA_BITS-1:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	// changed, delta_x, delta_y, delta_z, hit_delta_x, hit_delta_y, hit_delta_z
	logic [vcd_pkg::OUT_TDATA_BITS-1:0] m_tdata;
	logic cfg_we = 1'b0;
	logic [vcd_pkg::CFG_IDX_BITS-1:0] cfg_index = '0;
	logic [vcd_pkg::CFG_DATA_BITS-1:0] cfg_data = '0;

	vec3_change_detector_unit #(
		.SAMPLE_BITS(SAMPLE_W)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// model of the detector's registers and state
	logic [15:0]        thr_reg = '0;
	logic [1:0]         mode_reg = vcd_pkg::MODE_ANY;
	logic [31:0]        holdoff_reg = '0;
	logic               prevent_reg = 1'b0;
	logic signed [15:0] last_x = '0, last_y = '0, last_z = '0;
	logic [31:0]        hit_stamp = '0;
	logic               over_before = 1'b0;
	logic [15:0]        held_dx = '0, held_dy = '0, held_dz = '0;

	detection_t expected_detections[$];
	int error_count = 0;

	// stimulus pacing
	int  burst_left = 0;
	bit  sender_steady = 1'b0;
	bit  long_hold_req = 1'b0;
	logic [31:0] tick_now = '0;
	int walk_x = 0, walk_y = 0, walk_z = 0;

	function automatic logic exceeds_thr(int d);
		int t;
		t = int'(thr_reg);
		case (mode_reg)
			vcd_pkg::MODE_ANY: return (d > t) || (d < -t);
			vcd_pkg::MODE_INC: return d > t;
			default:  return d < -t;
		endcase
	endfunction

	function automatic logic signed [16:0] clip_delta(int d);
		if (d > DELTA_LIMIT) d = DELTA_LIMIT;
		if (d < -DELTA_LIMIT) d = -DELTA_LIMIT;
		return 17'(d);
	endfunction

	function automatic logic [15:0] clip_mag(int d);
		if (d < 0) d = -d;
		if (d > MAG_LIMIT) d = MAG_LIMIT;
		return 16'(d);
	endfunction

	task automatic predict_detection(input sample_t s);
		int dx, dy, dz;
		logic over;
		logic [31:0] elapsed;
		detection_t r;
		dx = int'(s.x) - int'(last_x);
		dy = int'(s.y) - int'(last_y);
		dz = int'(s.z) - int'(last_z);
		over = exceeds_thr(dx) || exceeds_thr(dy) || exceeds_thr(dz);
		r.changed = over;
		if (over && (prevent_reg || !over_before)) begin
			elapsed = s.ts - hit_stamp;
			if (elapsed >= holdoff_reg) begin
				hit_stamp = s.ts;
				held_dx = clip_mag(dx);
				held_dy = clip_mag(dy);
				held_dz = clip_mag(dz);
			end else begin
				// inside the holdoff window: candidate dropped
				r.changed = 1'b0;
			end
		end
		over_before = over;
		last_x = s.x;
		last_y = s.y;
		last_z = s.z;
		r.dx = clip_delta(dx);
		r.dy = clip_delta(dy);
		r.dz = clip_delta(dz);
		r.hx = held_dx;
		r.hy = held_dy;
		r.hz = held_dz;
		expected_detections.push_back(r);
	endtask

	task automatic send_sample(input logic [15:0] x, input logic [15:0] y,
		input logic [15:0] z, input logic [31:0] ts);
		sample_t s;
		int gap;
		s.x = x;
		s.y = y;
		s.z = z;
		s.ts = ts;
		if (!sender_steady) begin
			if (burst_left == 0) begin
				gap = $urandom_range(1, 6);
				burst_left = $urandom_range(1, 16);
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left--;
		end
		s_tvalid <= 1'b1;
		s_tdata <= {s.ts, s.z, s.y, s.x};
		do @(posedge clk); while (!s_tready);
		predict_detection(s);
	endtask

	// stop sending and let every outstanding beat come out
	task automatic wait_all_results();
		s_tvalid <= 1'b0;
		while (expected_detections.size() != 0) @(posedge clk);
		repeat (DRAIN_SLACK) @(posedge clk);
	endtask

	// junk above each register's width must be ignored
	task automatic write_settings(input logic [15:0] thr, input logic [1:0] mode,
		input logic [31:0] holdoff, input logic prevent);
		logic [31:0] junk;
		junk = $urandom;
		cfg_we <= 1'b1;
		cfg_index <= vcd_pkg::REG_THRESHOLD;
		cfg_data <= {junk[31:16], thr};
		@(posedge clk);
		cfg_index <= vcd_pkg::REG_MODE;
		cfg_data <= {junk[31:2], mode};
		@(posedge clk);
		cfg_index <= vcd_pkg::REG_HOLDOFF;
		cfg_data <= holdoff;
		@(posedge clk);
		cfg_index <= vcd_pkg::REG_PREVENT;
		cfg_data <= {junk[31:1], prevent};
		@(posedge clk);
		cfg_we <= 1'b0;
		thr_reg = thr;
		mode_reg = mode;
		holdoff_reg = holdoff;
		prevent_reg = prevent;
	endtask

	task automatic check_field(input string name, input logic signed [31:0] exp_v,
		input logic signed [31:0] act_v);
		if (act_v !== exp_v) begin
			$display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, exp_v, act_v);
			error_count++;
		end
	endtask

	always @(posedge clk) begin
		detection_t e;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_detections.size() == 0) begin
				$display("%0t: unexpected beat: expected none, actual %h", $time, m_tdata);
				error_count++;
			end else begin
				e = expected_detections.pop_front();
				check_field("changed", e.changed, m_tdata[0]);
				check_field("delta_x", e.dx, $signed(m_tdata[17:1]));
				check_field("delta_y", e.dy, $signed(m_tdata[34:18]));
				check_field("delta_z", e.dz, $signed(m_tdata[51:35]));
				check_field("hit_delta_x", e.hx, m_tdata[67:52]);
				check_field("hit_delta_y", e.hy, m_tdata[83:68]);
				check_field("hit_delta_z", e.hz, m_tdata[99:84]);
				check_field("padding", 0, m_tdata[vcd_pkg::OUT_TDATA_BITS-1:100]);
			end
		end
	end

	// receiver: segments of always-ready, coin-flip and sparse ready, plus long holds on request
	initial begin : result_sink
		int seg_left;
		int kind;
		seg_left = 0;
		kind = 0;
		forever begin
			@(posedge clk);
			if (long_hold_req) begin
				m_tready <= 1'b0;
				repeat (LONG_HOLD_CYC) @(posedge clk);
				long_hold_req = 1'b0;
			end
			if (seg_left == 0) begin
				kind = $urandom_range(0, 2);
				seg_left = $urandom_range(5, 60);
			end
			seg_left--;
			case (kind)
				0: m_tready <= 1'b1;
				1: m_tready <= 1'($urandom_range(0, 1));
				default: m_tready <= ($urandom_range(0, 3) == 0);
			endcase
		end
	end

	task automatic test_first_sample();
		// power-on settings: zero threshold, any change, no holdoff
		send_sample(16'sd0, 16'sd0, 16'sd0, 32'd5);
		send_sample(16'sd1, 16'sd0, 16'sd0, 32'd6);
		// held change without re-fire
		send_sample(16'sd2, 16'sd0, 16'sd0, 32'd7);
	endtask

	task automatic test_extremes();
		send_sample(16'h7FFF, 16'h8000, 16'h7FFF, 32'd8);
		send_sample(16'h8000, 16'h7FFF, 16'h8000, 32'd9);
		send_sample(16'h8000, 16'h8000, 16'h8000, 32'd10);
		send_sample(16'h7FFF, 16'h7FFF, 16'h7FFF, 32'd11);
	endtask

	task automatic test_modes();
		logic [1:0] m;
		wait_all_results();
		write_settings(HALF_Q88, vcd_pkg::MODE_ANY, 32'd0, 1'b0);
		send_sample(16'sd0, 16'sd0, 16'sd0, 32'd20);
		// all four codes, the spare one behaves as decrease-only
		for (int i = 0; i < 4; i++) begin
			m = 2'(i);
			wait_all_results();
			write_settings(HALF_Q88, m, 32'd0, 1'b0);
			send_sample(16'h0081, 16'sd0, 16'sd0, 32'd21 + 32'(i));
			send_sample(16'sd0, 16'sd0, 16'sd0, 32'd30 + 32'(i));
		end
		// exactly at threshold is not a change
		send_sample(16'sd0, HALF_Q88, 16'sd0, 32'd40);
	endtask

	task automatic test_holdoff();
		wait_all_results();
		write_settings(16'd0, vcd_pkg::MODE_ANY, 32'd100, 1'b1);
		send_sample(16'sd5, 16'sd5, 16'sd5, 32'hFFFF_FFC0);
		// elapsed wraps through zero: 80 ticks, too soon
		send_sample(16'sd6, 16'sd5, 16'sd5, 32'h0000_0010);
		send_sample(16'sd7, 16'sd5, 16'sd5, 32'h0000_0030);
		wait_all_results();
		write_settings(16'd0, vcd_pkg::MODE_ANY, 32'hFFFF_FFFF, 1'b1);
		send_sample(16'sd8, 16'sd5, 16'sd5, 32'h0000_0031);
		wait_all_results();
		write_settings(16'hFFFF, vcd_pkg::MODE_ANY, 32'd0, 1'b0);
		send_sample(16'h8000, 16'h8000, 16'h8000, 32'h0000_0040);
		send_sample(16'h7FFF, 16'h7FFF, 16'h7FFF, 32'h0000_0041);
	endtask

	function automatic int walk_step(int v, int span);
		v = v + $urandom_range(0, 2 * span) - span;
		if (v > 32767) v = 32767;
		if (v < -32768) v = -32768;
		return v;
	endfunction

	task automatic send_random_sample();
		int r;
		int span;
		int tick_span;
		r = $urandom_range(0, 99);
		span = int'(thr_reg) + 64;
		if (span > 20000) span = 20000;
		if (r < 10) begin
			walk_x = $signed(16'($urandom));
			walk_y = $signed(16'($urandom));
			walk_z = $signed(16'($urandom));
		end else if (r >= 25) begin
			walk_x = walk_step(walk_x, span);
			walk_y = walk_step(walk_y, span);
			walk_z = walk_step(walk_z, span);
		end
		tick_span = (holdoff_reg < 32'd1000) ? int'(holdoff_reg) * 2 + 4 : 2000;
		if ($urandom_range(0, 19) == 0)
			tick_now = $urandom;
		else
			tick_now = tick_now + 32'($urandom_range(0, tick_span));
		send_sample(16'(walk_x), 16'(walk_y), 16'(walk_z), tick_now);
	endtask

	task automatic test_backpressure();
		wait_all_results();
		write_settings(16'd16, vcd_pkg::MODE_ANY, 32'd3, 1'b1);
		sender_steady = 1'b1;
		long_hold_req = 1'b1;
		repeat (40) send_random_sample();
		sender_steady = 1'b0;
	endtask

	task automatic test_random();
		logic [15:0] thr;
		logic [31:0] holdoff;
		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			case (phase % 5)
				0: thr = 16'd0;
				1: thr = 16'hFFFF;
				2: thr = 16'($urandom_range(0, 255));
				default: thr = 16'($urandom_range(0, 4095));
			endcase
			if (phase == RANDOM_PHASES - 1) thr = 16'($urandom);
			case (phase % 4)
				0: holdoff = 32'd0;
				1: holdoff = $urandom_range(0, 40);
				2: holdoff = (phase == 2) ? 32'hFFFF_FFFF : $urandom_range(0, 200);
				default: holdoff = $urandom;
			endcase
			wait_all_results();
			write_settings(thr, 2'(phase % 4), holdoff, 1'((phase / 2) % 2));
			sender_steady = (phase % 3 == 2);
			repeat (PHASE_BEATS) send_random_sample();
		end
		sender_steady = 1'b0;
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_first_sample();
		test_extremes();
		test_modes();
		test_holdoff();
		test_backpressure();
		test_random();
		wait_all_results();
		if (error_count == 0 && expected_detections.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		#(TIMEOUT_NS);
		$display("RESULT: ERROR");
		$finish;
	end

endmodule

### filelist.f
design/vcd_pkg.sv
design/vcd_lane.sv
design/vcd_merge.sv
design/vec3_change_detector_unit.sv
design/vcd_checker.sv
tb/vec3_change_detector_unit_test.sv
